// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the aimer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- rtl/pidaim_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaim_pkg
// Types, widths and constants shared by the two-axis PID servo aimer.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaim_pkg;

   localparam int ERR_W   = 12;
   localparam int GAIN_W  = 12;
   localparam int LIM_W   = 11;
   localparam int PULSE_W = 12;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int PROD_W  = 26;
   localparam int ACC_W   = PROD_W + 2;
   localparam int FRAC_W  = 8;
   localparam int QUO_W   = ACC_W - FRAC_W;
   localparam int POS_W   = PULSE_W + 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE_MAX   = 3'd5;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET      = 12'd768;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET      = 12'd26;
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET      = 12'd384;
   localparam logic [LIM_W-1:0]   DRIVE_LIMIT_RESET = 11'd300;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RESET   = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RESET   = 12'd2500;
   localparam logic [PULSE_W-1:0] POSITION_RESET    = 12'd1500;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIM_W-1:0]   drive_limit;
      logic [PULSE_W-1:0] pulse_min;
      logic [PULSE_W-1:0] pulse_max;
   } cfg_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] p_term;
      logic signed [PROD_W-1:0] i_term;
      logic signed [PROD_W-1:0] d_term;
   } axis_terms_type;

   typedef struct packed {
      logic           found;
      axis_terms_type yaw;
      axis_terms_type pitch;
   } stage_type;

endpackage

`default_nettype wire

// ----- rtl/pidaim_front.sv -----
// ----------------------------------------------------------------------------
// pidaim_front
// Integral and derivative state of both axes and the registered gain products.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaim_front
   import pidaim_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire logic signed [ERR_W-1:0] err_x,
   input  wire logic signed [ERR_W-1:0] err_y,
   input  wire logic                    found,
   input  wire cfg_type                 cfg,
   output      stage_type               stage
);

   logic signed [ERR_W-1:0] yaw_sum_ff, yaw_sum_in;
   logic signed [ERR_W-1:0] yaw_last_ff, yaw_last_in;
   logic signed [ERR_W-1:0] pitch_sum_ff, pitch_sum_in;
   logic signed [ERR_W-1:0] pitch_last_ff, pitch_last_in;
   stage_type               stage_ff, stage_in;

   function automatic logic signed [ERR_W-1:0] clamp_sum(
      input logic signed [DIFF_W-1:0] v,
      input logic [LIM_W-1:0]         lim
   );
      logic signed [DIFF_W-1:0] hi;
      logic signed [DIFF_W-1:0] lo;
      hi = signed'({{(DIFF_W-LIM_W){1'b0}}, lim});
      lo = -hi;
      if (v > hi) begin
         return hi[ERR_W-1:0];
      end else if (v < lo) begin
         return lo[ERR_W-1:0];
      end
      return v[ERR_W-1:0];
   endfunction

   function automatic axis_terms_type axis_terms(
      input logic signed [ERR_W-1:0] e,
      input logic signed [ERR_W-1:0] s,
      input logic signed [ERR_W-1:0] last,
      input cfg_type                 c
   );
      axis_terms_type           t;
      logic signed [DIFF_W-1:0] d;
      logic signed [GAIN_W:0]   gp, gi, gd;
      d  = DIFF_W'(e) - DIFF_W'(last);
      gp = signed'({1'b0, c.gain_p});
      gi = signed'({1'b0, c.gain_i});
      gd = signed'({1'b0, c.gain_d});
      t.p_term = PROD_W'(gp) * PROD_W'(e);
      t.i_term = PROD_W'(gi) * PROD_W'(s);
      t.d_term = PROD_W'(gd) * PROD_W'(d);
      return t;
   endfunction

   always_comb begin
      yaw_sum_in    = clamp_sum(DIFF_W'(yaw_sum_ff) + DIFF_W'(err_x), cfg.drive_limit);
      pitch_sum_in  = clamp_sum(DIFF_W'(pitch_sum_ff) + DIFF_W'(err_y), cfg.drive_limit);
      yaw_last_in   = err_x;
      pitch_last_in = err_y;
      stage_in.found = found;
      stage_in.yaw   = axis_terms(err_x, yaw_sum_in, yaw_last_ff, cfg);
      stage_in.pitch = axis_terms(err_y, pitch_sum_in, pitch_last_ff, cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_sum_ff    <= '0;
         yaw_last_ff   <= '0;
         pitch_sum_ff  <= '0;
         pitch_last_ff <= '0;
      end else if (load && found) begin
         yaw_sum_ff    <= yaw_sum_in;
         yaw_last_ff   <= yaw_last_in;
         pitch_sum_ff  <= pitch_sum_in;
         pitch_last_ff <= pitch_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// ----- rtl/pidaim_back.sv -----
// ----------------------------------------------------------------------------
// pidaim_back
// Sums the gain products, scales and limits the correction, and moves the
// servo positions, which also serve as the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaim_back
   import pidaim_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire stage_type         stage,
   input  wire cfg_type           cfg,
   output      logic [PULSE_W-1:0] yaw_pulse,
   output      logic [PULSE_W-1:0] pitch_pulse
);

   logic [PULSE_W-1:0]      yaw_pos_ff, yaw_pos_in;
   logic [PULSE_W-1:0]      pitch_pos_ff, pitch_pos_in;
   logic signed [ERR_W-1:0] yaw_corr, pitch_corr;

   function automatic logic signed [ERR_W-1:0] correction(
      input axis_terms_type   t,
      input logic [LIM_W-1:0] lim
   );
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] biased;
      logic signed [QUO_W-1:0] q;
      logic signed [QUO_W-1:0] hi;
      logic signed [QUO_W-1:0] lo;
      acc = ACC_W'(t.p_term) + ACC_W'(t.i_term) + ACC_W'(t.d_term);
      biased = acc[ACC_W-1] ? acc + ACC_W'((1 << FRAC_W) - 1) : acc;
      q  = signed'(biased[ACC_W-1:FRAC_W]);
      hi = signed'({{(QUO_W-LIM_W){1'b0}}, lim});
      lo = -hi;
      if (q > hi) begin
         return hi[ERR_W-1:0];
      end else if (q < lo) begin
         return lo[ERR_W-1:0];
      end
      return q[ERR_W-1:0];
   endfunction

   function automatic logic [PULSE_W-1:0] clamp_pulse(
      input logic signed [POS_W-1:0] v,
      input cfg_type                 c
   );
      logic signed [POS_W-1:0] r;
      logic signed [POS_W-1:0] lo;
      logic signed [POS_W-1:0] hi;
      lo = signed'({2'b00, c.pulse_min});
      hi = signed'({2'b00, c.pulse_max});
      r  = v;
      if (r < lo) begin
         r = lo;
      end
      if (r > hi) begin
         r = hi;
      end
      return r[PULSE_W-1:0];
   endfunction

   always_comb begin
      yaw_corr     = correction(stage.yaw, cfg.drive_limit);
      pitch_corr   = correction(stage.pitch, cfg.drive_limit);
      yaw_pos_in   = clamp_pulse(signed'({2'b00, yaw_pos_ff}) + POS_W'(yaw_corr), cfg);
      pitch_pos_in = clamp_pulse(signed'({2'b00, pitch_pos_ff}) - POS_W'(pitch_corr), cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_pos_ff   <= POSITION_RESET;
         pitch_pos_ff <= POSITION_RESET;
      end else if (advance && stage.found) begin
         yaw_pos_ff   <= yaw_pos_in;
         pitch_pos_ff <= pitch_pos_in;
      end
   end

   assign yaw_pulse   = yaw_pos_ff;
   assign pitch_pulse = pitch_pos_ff;

endmodule

`default_nettype wire

// ----- rtl/two_axis_pid_servo_aimer_top.sv -----
// The aimer takes one camera report per clock cycle while the result channel
// keeps up. An accepted report is registered in the stage register; when that
// stage advances, rsp_tvalid rises with both servo pulse widths. The stage
// waits while a held result is stalled. Accepting a found report updates the
// integrals and previous errors; each accepted report registers the three gain
// products of each axis. Advancing a found report forms the scaled, limited
// correction and moves the servo positions, held as the result. Each feedback
// loop (integral, previous error, servo position) closes through one register.
// ----------------------------------------------------------------------------
// two_axis_pid_servo_aimer_top
// Two-axis PID servo aimer with shared gains and clamped integral and output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module two_axis_pid_servo_aimer_top
   import pidaim_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [23:0]           req_tdata,   // err_x, err_y
   input  wire logic                  req_tuser,   // found

   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [23:0]           rsp_tdata,   // yaw_pulse, pitch_pulse

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type            cfg_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               advance;
   stage_type          stage;
   logic [PULSE_W-1:0] yaw_pulse, pitch_pulse;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p      <= GAIN_P_RESET;
         cfg_ff.gain_i      <= GAIN_I_RESET;
         cfg_ff.gain_d      <= GAIN_D_RESET;
         cfg_ff.drive_limit <= DRIVE_LIMIT_RESET;
         cfg_ff.pulse_min   <= PULSE_MIN_RESET;
         cfg_ff.pulse_max   <= PULSE_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GAIN_P:      cfg_ff.gain_p      <= csr_data[GAIN_W-1:0];
            REG_GAIN_I:      cfg_ff.gain_i      <= csr_data[GAIN_W-1:0];
            REG_GAIN_D:      cfg_ff.gain_d      <= csr_data[GAIN_W-1:0];
            REG_DRIVE_LIMIT: cfg_ff.drive_limit <= csr_data[LIM_W-1:0];
            REG_PULSE_MIN:   cfg_ff.pulse_min   <= csr_data[PULSE_W-1:0];
            REG_PULSE_MAX:   cfg_ff.pulse_max   <= csr_data[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   pidaim_front u_front (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .err_x (signed'(req_tdata[ERR_W-1:0])),
      .err_y (signed'(req_tdata[2*ERR_W-1:ERR_W])),
      .found (req_tuser),
      .cfg   (cfg_ff),
      .stage (stage)
   );

   pidaim_back u_back (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .stage       (stage),
      .cfg         (cfg_ff),
      .yaw_pulse   (yaw_pulse),
      .pitch_pulse (pitch_pulse)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pitch_pulse, yaw_pulse};

   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, accept, s1_valid_ff)
   `ASSERT_NEXT(a_stalled_stage_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   `ASSERT_NEXT(a_pulse_in_range, clock, reset,
      advance && stage.found && !csr_valid && (cfg_ff.pulse_min <= cfg_ff.pulse_max),
      (yaw_pulse >= cfg_ff.pulse_min) && (yaw_pulse <= cfg_ff.pulse_max) &&
      (pitch_pulse >= cfg_ff.pulse_min) && (pitch_pulse <= cfg_ff.pulse_max))
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !s1_valid_ff, req_tready)

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-axis PID servo aimer. Camera reports go in on
// the request stream, the register file is written through the CSR channel
// while the aimer is idle, and every pulse pair that comes back is compared
// with a behavioral model of the PID loops kept inside the bench. Directed
// reports cover the extremes first, then random reports run under several
// gain and range settings: first under a long receiver hold-off, then under
// four patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import pidaim_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 8;
   localparam int YAW          = 0;
   localparam int PITCH        = 1;
   localparam int PHASE_ITEMS  = 125;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   typedef struct packed {
      logic                    found;
      logic signed [ERR_W-1:0] err_y;
      logic signed [ERR_W-1:0] err_x;
   } report_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pitch_pulse;
      logic [PULSE_W-1:0] yaw_pulse;
   } pulses_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;    // err_x, err_y
   logic                  req_tuser  = 1'b0;  // found
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;          // yaw_pulse, pitch_pulse
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   cfg_type    aim_cfg;
   int         integ[2];
   int         prev_err[2];
   int         servo_pos[2];
   pulses_type pulses_pending[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold      = 0;
   int fail_count    = 0;
   int reports_sent  = 0;
   int pulses_checked = 0;
   int csr_writes    = 0;
   int idle_cycles   = 0;

   two_axis_pid_servo_aimer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp_sym(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic int axis_correction(int axis, int e);
      int lim, gp, gi, gd, acc;
      lim = aim_cfg.drive_limit;
      gp  = aim_cfg.gain_p;
      gi  = aim_cfg.gain_i;
      gd  = aim_cfg.gain_d;
      integ[axis] = clamp_sym(integ[axis] + e, lim);
      acc = gp * e + gi * integ[axis] + gd * (e - prev_err[axis]);
      prev_err[axis] = e;
      return clamp_sym(acc / 256, lim);
   endfunction

   // The lower bound goes first, so an inverted range ends at pulse_max.
   function automatic int clamp_pulse(int v);
      int lo, hi;
      lo = aim_cfg.pulse_min;
      hi = aim_cfg.pulse_max;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic pulses_type predict_pulses(report_type r);
      pulses_type p;
      int ex, ey, cy, cp;
      ex = r.err_x;
      ey = r.err_y;
      if (r.found) begin
         cy = axis_correction(YAW, ex);
         cp = axis_correction(PITCH, ey);
         servo_pos[YAW]   = clamp_pulse(servo_pos[YAW] + cy);
         servo_pos[PITCH] = clamp_pulse(servo_pos[PITCH] - cp);
      end
      p.yaw_pulse   = PULSE_W'(servo_pos[YAW]);
      p.pitch_pulse = PULSE_W'(servo_pos[PITCH]);
      return p;
   endfunction

   function automatic void store_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_GAIN_P:      aim_cfg.gain_p = value;
         REG_GAIN_I:      aim_cfg.gain_i = value;
         REG_GAIN_D:      aim_cfg.gain_d = value;
         REG_DRIVE_LIMIT: aim_cfg.drive_limit = value[LIM_W-1:0];
         REG_PULSE_MIN:   aim_cfg.pulse_min = value;
         REG_PULSE_MAX:   aim_cfg.pulse_max = value;
         default: ;
      endcase
   endfunction

   function automatic logic [ERR_W-1:0] random_err();
      case ($urandom_range(9))
         0: return ERR_W'($urandom);
         1: return $urandom_range(1) ? 12'h7FF : 12'h800;
         2: return ERR_W'($urandom_range(1024) - 512);
         default: return ERR_W'($urandom_range(128) - 64);
      endcase
   endfunction

   function automatic report_type random_report();
      report_type r;
      r.err_x = random_err();
      r.err_y = random_err();
      r.found = ($urandom_range(99) < 85);
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_gain();
      case ($urandom_range(5))
         0: return 12'd0;
         1: return 12'hFFF;
         2: return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(1023));
      endcase
   endfunction

   function automatic report_type make_report(int ex, int ey, logic fnd);
      report_type r;
      r.err_x = ERR_W'(ex);
      r.err_y = ERR_W'(ey);
      r.found = fnd;
      return r;
   endfunction

   // Every task below starts and ends on a rising clock edge.
   task automatic send_report(report_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.err_y, r.err_x};
      req_tuser  <= r.found;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pulses_pending.push_back(predict_pulses(r));
      reports_sent++;
   endtask

   task automatic drain_pulses();
      req_tvalid <= 1'b0;
      while (pulses_pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      store_reg(idx, value);
      csr_writes++;
   endtask

   // Called only with nothing in flight and never twice without a report between.
   task automatic configure(logic [CSR_DATA_W-1:0] gp, logic [CSR_DATA_W-1:0] gi,
                            logic [CSR_DATA_W-1:0] gd, logic [CSR_DATA_W-1:0] lim,
                            logic [CSR_DATA_W-1:0] lo, logic [CSR_DATA_W-1:0] hi);
      write_reg(REG_GAIN_P, gp);
      write_reg(REG_GAIN_I, gi);
      write_reg(REG_GAIN_D, gd);
      write_reg(REG_DRIVE_LIMIT, lim);
      write_reg(REG_PULSE_MIN, lo);
      write_reg(REG_PULSE_MAX, hi);
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic random_settings();
      logic [CSR_DATA_W-1:0] lim, lo, hi;
      case ($urandom_range(5))
         0: lim = 12'd0;
         1: lim = 12'h7FF;
         2: lim = CSR_DATA_W'($urandom);
         default: lim = CSR_DATA_W'($urandom_range(600, 1));
      endcase
      case ($urandom_range(5))
         0: begin
            lo = 12'd0;
            hi = 12'hFFF;
         end
         1: begin
            lo = CSR_DATA_W'($urandom_range(4095, 2000));
            hi = CSR_DATA_W'($urandom_range(1999, 0));
         end
         default: begin
            lo = CSR_DATA_W'($urandom_range(1500, 0));
            hi = CSR_DATA_W'($urandom_range(4095, 1500));
         end
      endcase
      configure(random_gain(), random_gain(), random_gain(), lim, lo, hi);
   endtask

   task automatic test_directed_cases();
      send_report(make_report(0, 0, 1'b0));
      send_report(make_report(0, 0, 1'b1));
      send_report(make_report(2047, -2048, 1'b1));
      send_report(make_report(-2048, 2047, 1'b1));
      send_report(make_report(-1, 1, 1'b1));
      send_report(make_report(1, -1, 1'b1));
      send_report(make_report(-2048, -2048, 1'b0));
      drain_pulses();
      configure(12'hFFF, 12'hFFF, 12'hFFF, 12'h7FF, 12'd0, 12'hFFF);
      send_report(make_report(2047, 2047, 1'b1));
      send_report(make_report(-2048, -2048, 1'b1));
      send_report(make_report(-2048, 2047, 1'b1));
      drain_pulses();
      // Positions outside a newly narrowed range are reported unchanged while lost.
      configure(12'd256, 12'd0, 12'd0, 12'd100, 12'd1000, 12'd1200);
      send_report(make_report(2047, -2048, 1'b0));
      send_report(make_report(3, -3, 1'b1));
      drain_pulses();
      configure(12'd256, 12'd26, 12'd0, 12'd50, 12'd3000, 12'd100);
      send_report(make_report(10, -10, 1'b1));
      send_report(make_report(0, 0, 1'b0));
      drain_pulses();
      configure(12'hFFF, 12'hFFF, 12'hFFF, 12'h800, 12'd500, 12'd2500);
      send_report(make_report(2047, -2048, 1'b1));
      send_report(make_report(-700, 700, 1'b1));
      drain_pulses();
      configure(12'd0, 12'd0, 12'd0, 12'd300, 12'd500, 12'd2500);
      send_report(make_report(1234, -1234, 1'b1));
      drain_pulses();
      configure(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET, CSR_DATA_W'(DRIVE_LIMIT_RESET),
                PULSE_MIN_RESET, PULSE_MAX_RESET);
      send_report(make_report(40, -25, 1'b1));
      send_report(make_report(-7, 9, 1'b1));
   endtask

   // The receiver holds off while reports keep coming, so the input must stall.
   task automatic test_backpressure();
      drain_pulses();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      random_settings();
      rsp_hold = 80;
      repeat (40) send_report(random_report());
      drain_pulses();
   endtask

   task automatic test_idle_phases();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 45;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 45;
            end
            default: begin
               send_idle_pct = 28;
               rsp_stall_pct = 28;
            end
         endcase
         for (int set = 0; set < 3; set++) begin
            drain_pulses();
            random_settings();
            repeat (PHASE_ITEMS) send_report(random_report());
         end
      end
   endtask

   task automatic finish_run();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      drain_pulses();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d camera reports and checked %0d pulse pairs.", reports_sent,
               pulses_checked);
      $display("Made %0d register writes, with a long receiver hold-off and four idle patterns.",
               csr_writes);
      if (fail_count == 0) begin
         $display("two_axis_pid_servo_aimer_top: match");
      end else begin
         $display("two_axis_pid_servo_aimer_top: mismatch");
      end
      $finish;
   endtask

   always @(posedge clock) begin : rsp_side
      pulses_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pulses_pending.size() == 0) begin
               $display("%0t: unexpected pulse pair yaw %0d pitch %0d", $time,
                        got.yaw_pulse, got.pitch_pulse);
               fail_count++;
            end else begin
               want = pulses_pending.pop_front();
               if (got.yaw_pulse !== want.yaw_pulse) begin
                  $display("%0t: yaw pulse expected %0d, got %0d", $time,
                           want.yaw_pulse, got.yaw_pulse);
                  fail_count++;
               end
               if (got.pitch_pulse !== want.pitch_pulse) begin
                  $display("%0t: pitch pulse expected %0d, got %0d", $time,
                           want.pitch_pulse, got.pitch_pulse);
                  fail_count++;
               end
               pulses_checked++;
            end
         end
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("two_axis_pid_servo_aimer_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      aim_cfg.gain_p      = GAIN_P_RESET;
      aim_cfg.gain_i      = GAIN_I_RESET;
      aim_cfg.gain_d      = GAIN_D_RESET;
      aim_cfg.drive_limit = DRIVE_LIMIT_RESET;
      aim_cfg.pulse_min   = PULSE_MIN_RESET;
      aim_cfg.pulse_max   = PULSE_MAX_RESET;
      integ     = '{0, 0};
      prev_err  = '{0, 0};
      servo_pos = '{int'(POSITION_RESET), int'(POSITION_RESET)};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_backpressure();
      test_idle_phases();
      finish_run();
   end

endmodule

`default_nettype wire

// ----- two_axis_pid_servo_aimer_top.f -----
+incdir+rtl
rtl/pidaim_pkg.sv
rtl/pidaim_front.sv
rtl/pidaim_back.sv
rtl/two_axis_pid_servo_aimer_top.sv
tb/testbench.sv
